FILE: hdl/lc_pkg.sv
`timescale 1ns / 1ps
package lc_pkg;
    localparam int unsigned CoordW = 32;
    localparam int unsigned NumRegs = 4;
    localparam int unsigned IdxW = 2;
    localparam int unsigned ProdW = 66;
    localparam int unsigned MagW = 65;
    localparam logic [IdxW-1:0] RegXMin = 2'd0;
    localparam logic [IdxW-1:0] RegXMax = 2'd1;
    localparam logic [IdxW-1:0] RegYMin = 2'd2;
    localparam logic [IdxW-1:0] RegYMax = 2'd3;
    localparam logic [3:0] RcLeft  = 4'd1;
    localparam logic [3:0] RcRight = 4'd2;
    localparam logic [3:0] RcBelow = 4'd4;
    localparam logic [3:0] RcAbove = 4'd8;

    typedef struct packed {
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] end_x;
        logic [CoordW-1:0] end_y;
    } t_line;

    typedef struct packed {
        logic [CoordW-1:0] clipped_start_x;
        logic [CoordW-1:0] clipped_start_y;
        logic [CoordW-1:0] clipped_end_x;
        logic [CoordW-1:0] clipped_end_y;
        logic              visible;
    } t_result;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_start;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic accept;
        logic div_done;
    } t_status;
endpackage

FILE: hdl/lc_if.sv
`timescale 1ns / 1ps
interface lc_line_if;
    logic valid;
    logic ready;
    lc_pkg::t_line data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lc_result_if;
    logic valid;
    logic ready;
    lc_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lc_cfg_if;
    logic valid;
    logic ready;
    logic [lc_pkg::IdxW-1:0] index;
    logic [lc_pkg::CoordW-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hdl/lc_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module lc_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lc_pkg::MagW-1:0]    i_dividend,
    input  logic [lc_pkg::MagW-1:0]    i_divisor,
    output logic                       o_done,
    output logic [lc_pkg::MagW-1:0]    o_quotient
);
    localparam int unsigned CntW = $clog2(lc_pkg::MagW + 1);
    logic [lc_pkg::MagW-1:0] r_quo;
    logic [lc_pkg::MagW:0]   r_rem;
    logic [lc_pkg::MagW-1:0] r_den;
    logic [CntW-1:0]         r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic [lc_pkg::MagW:0]   n_trial;
    logic [lc_pkg::MagW:0]   n_shift;

    always_comb begin
        n_shift = {r_rem[lc_pkg::MagW-1:0], r_quo[lc_pkg::MagW-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CntW'(lc_pkg::MagW);
            end else if (r_busy) begin
                if (!n_trial[lc_pkg::MagW]) begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[lc_pkg::MagW-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[lc_pkg::MagW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

FILE: hdl/lc_datapath.sv
`timescale 1ns / 1ps
module lc_datapath (
    input  logic                         i_clk,
    input  lc_pkg::t_cmd                 i_cmd,
    input  lc_pkg::t_line                i_line,
    input  logic signed [lc_pkg::CoordW-1:0] i_x_min,
    input  logic signed [lc_pkg::CoordW-1:0] i_x_max,
    input  logic signed [lc_pkg::CoordW-1:0] i_y_min,
    input  logic signed [lc_pkg::CoordW-1:0] i_y_max,
    input  logic                         i_rst_n,
    output lc_pkg::t_status              o_status,
    output lc_pkg::t_line                o_line
);
    localparam int unsigned W = lc_pkg::CoordW;
    logic signed [W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [3:0] r_c1, r_c2;
    logic [3:0] n_c1, n_c2, n_c;
    logic signed [W-1:0] r_edge, r_base;
    logic                r_on_y, r_move_start;
    logic signed [W:0]   r_span, r_num, r_den;
    logic [W-1:0]        r_mspan, r_mnum;
    logic [W:0]          r_mden;
    logic                r_neg;
    logic [lc_pkg::MagW-1:0] r_prod;
    logic                div_done;
    logic [lc_pkg::MagW-1:0] div_q;
    logic signed [W:0]   dx, dy;
    logic [W-1:0]        q32;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] n_res;

    function automatic logic [3:0] region(input logic signed [W-1:0] x,
                                          input logic signed [W-1:0] y,
                                          input logic signed [W-1:0] xl,
                                          input logic signed [W-1:0] xh,
                                          input logic signed [W-1:0] yl,
                                          input logic signed [W-1:0] yh);
        logic [3:0] c;
        c = '0;
        if (x < xl) c = c | lc_pkg::RcLeft;
        else if (x > xh) c = c | lc_pkg::RcRight;
        if (y < yl) c = c | lc_pkg::RcBelow;
        else if (y > yh) c = c | lc_pkg::RcAbove;
        return c;
    endfunction

    always_comb begin
        n_c1 = region(r_sx, r_sy, i_x_min, i_x_max, i_y_min, i_y_max);
        n_c2 = region(r_ex, r_ey, i_x_min, i_x_max, i_y_min, i_y_max);
        n_c  = (r_c1 != '0) ? r_c1 : r_c2;
        dx = (W+1)'(r_ex) - (W+1)'(r_sx);
        dy = (W+1)'(r_ey) - (W+1)'(r_sy);
        q32 = (div_q > lc_pkg::MagW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_q[W-1:0];
        sum = r_neg ? ((W+2)'(r_base) - $signed({2'b00, q32}))
                    : ((W+2)'(r_base) + $signed({2'b00, q32}));
        if (sum > (W+2)'(32'sh7FFF_FFFF)) n_res = 32'sh7FFF_FFFF;
        else if (sum < -(W+2)'(64'sh8000_0000)) n_res = 32'sh8000_0000;
        else n_res = sum[W-1:0];
    end

    lc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  ({32'd0, r_mden}),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_line.start_x;
            r_sy <= i_line.start_y;
            r_ex <= i_line.end_x;
            r_ey <= i_line.end_y;
        end
        if (i_cmd.eval) begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
        end
        // choose edge and operands for this clip step
        if (i_cmd.mul) begin
            r_move_start <= (r_c1 != '0);
            if ((n_c & lc_pkg::RcAbove) != '0 || (n_c & lc_pkg::RcBelow) != '0) begin
                r_edge <= ((n_c & lc_pkg::RcAbove) != '0) ? i_y_max : i_y_min;
                r_on_y <= 1'b1;
                r_base <= r_sx;
                r_span <= dx;
                r_den  <= dy;
                r_num  <= (W+1)'(((n_c & lc_pkg::RcAbove) != '0) ? i_y_max : i_y_min)
                          - (W+1)'(r_sy);
            end else begin
                r_edge <= ((n_c & lc_pkg::RcRight) != '0) ? i_x_max : i_x_min;
                r_on_y <= 1'b0;
                r_base <= r_sy;
                r_span <= dy;
                r_den  <= dx;
                r_num  <= (W+1)'(((n_c & lc_pkg::RcRight) != '0) ? i_x_max : i_x_min)
                          - (W+1)'(r_sx);
            end
        end
        if (i_cmd.apply) begin
            if (r_move_start) begin
                r_sx <= r_on_y ? n_res : r_edge;
                r_sy <= r_on_y ? r_edge : n_res;
            end else begin
                r_ex <= r_on_y ? n_res : r_edge;
                r_ey <= r_on_y ? r_edge : n_res;
            end
        end
    end

    // operand conditioning in the cycle after selection, then the product
    logic r_mag_v, r_prod_v;
    always_ff @(posedge i_clk) begin
        r_mag_v  <= i_cmd.mul;
        r_prod_v <= r_mag_v;
        if (r_mag_v) begin
            r_mspan <= r_span[W] ? W'(-r_span) : r_span[W-1:0];
            r_mnum  <= r_num[W]  ? W'(-r_num)  : r_num[W-1:0];
            r_mden  <= r_den[W]  ? (W+1)'(-r_den) : r_den;
            r_neg   <= (r_span[W] ^ r_num[W]) ^ r_den[W];
        end
        if (r_prod_v) begin
            r_prod <= lc_pkg::MagW'(r_mspan) * lc_pkg::MagW'(r_mnum);
        end
    end

    assign o_status.reject   = (r_c1 & r_c2) != '0;
    assign o_status.accept   = (r_c1 == '0) && (r_c2 == '0);
    assign o_status.div_done = div_done;
    assign o_line = '{start_x: r_sx, start_y: r_sy, end_x: r_ex, end_y: r_ey};
endmodule

FILE: hdl/lc_control.sv
`timescale 1ns / 1ps
module lc_control #(
    parameter int unsigned MAX_CLIPS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_visible,
    output lc_pkg::t_cmd    o_cmd,
    input  lc_pkg::t_status i_status
);
    localparam int unsigned StepW = $clog2(MAX_CLIPS + 1);
    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_DECIDE, S_SEL, S_MAG, S_MUL, S_START, S_DIV, S_DONE
    } t_state;
    t_state          r_state;
    logic [StepW-1:0] r_step;
    logic            r_vis;

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.mul       = (r_state == S_SEL);
        o_cmd.div_start = (r_state == S_START);
        o_cmd.apply     = (r_state == S_DIV) && i_status.div_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_vis   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_step  <= '0;
                    r_state <= S_EVAL;
                end
                S_EVAL: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_status.reject) begin
                        r_vis <= 1'b0;
                        r_state <= S_DONE;
                    end else if (i_status.accept) begin
                        r_vis <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_step == StepW'(MAX_CLIPS)) begin
                        r_vis <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: r_state <= S_MAG;
                S_MAG: r_state <= S_MUL;
                S_MUL: r_state <= S_START;
                S_START: r_state <= S_DIV;
                S_DIV: if (i_status.div_done) begin
                    r_step  <= r_step + 1'b1;
                    r_state <= S_EVAL;
                end
                S_DONE: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_visible   = r_vis;
endmodule

FILE: hdl/line_clipper.sv
`timescale 1ns / 1ps
// line_clipper: Cohen-Sutherland clipping of one segment against a window
// channels: s_line (sink) takes start/end points in signed Q16.16,
//   m_result (source) gives clipped endpoints and a visible flag,
//   s_cfg writes window registers: 0 x_min, 1 x_max, 2 y_min, 3 y_max
// config writes are taken every cycle and must only come while idle
// each clip step selects an edge, conditions the operands, forms a 32x32
//   product and runs the 65-bit serial restoring divider, then re-evaluates;
//   at most MAX_CLIPS steps are run per line
// one line is in flight at a time; ready drops from accept until the
//   result item is taken
// a rejected line, or one not settled after MAX_CLIPS steps, gives
//   visible 0 and zero coordinates
// reset puts the window back to x,y in [0, 7fffffff] and drops valid
// a stalled receiver holds the result; no new line is taken meanwhile
module line_clipper #(
    parameter int unsigned MAX_CLIPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lc_line_if.sink     s_line,
    lc_result_if.source m_result,
    lc_cfg_if.sink      s_cfg
);
    logic signed [lc_pkg::CoordW-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    lc_pkg::t_cmd    cmd;
    lc_pkg::t_status status;
    lc_pkg::t_line   line_q;
    logic            vis;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_x_max <= 32'sh7FFF_FFFF;
            r_y_min <= '0;
            r_y_max <= 32'sh7FFF_FFFF;
        end else if (s_cfg.valid) begin
            unique case (s_cfg.index)
                lc_pkg::RegXMin: r_x_min <= s_cfg.wdata;
                lc_pkg::RegXMax: r_x_max <= s_cfg.wdata;
                lc_pkg::RegYMin: r_y_min <= s_cfg.wdata;
                lc_pkg::RegYMax: r_y_max <= s_cfg.wdata;
                default: ;
            endcase
        end
    end
    assign s_cfg.ready = 1'b1;

    lc_control #(.MAX_CLIPS(MAX_CLIPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_line.valid),
        .o_in_ready  (s_line.ready),
        .o_out_valid (m_result.valid),
        .i_out_ready (m_result.ready),
        .o_visible   (vis),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lc_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_line   (s_line.data),
        .i_x_min  (r_x_min),
        .i_x_max  (r_x_max),
        .i_y_min  (r_y_min),
        .i_y_max  (r_y_max),
        .i_rst_n  (i_rst_n),
        .o_status (status),
        .o_line   (line_q)
    );

    // zero coordinates when not visible
    assign m_result.data.clipped_start_x = vis ? line_q.start_x : '0;
    assign m_result.data.clipped_start_y = vis ? line_q.start_y : '0;
    assign m_result.data.clipped_end_x   = vis ? line_q.end_x : '0;
    assign m_result.data.clipped_end_y   = vis ? line_q.end_y : '0;
    assign m_result.data.visible         = vis;
endmodule
